>>> rtl/php_pkg.sv
// Shared types and constants for the proximity haptic pulser.
// Holds the beat layouts, item codes, register indexes and reset values.
// No dependencies; every other file in rtl imports this package.
package php_pkg;

    // Operand widths of the interval mapping datapath
    localparam int OFS_W  = 14;             // distance offset and window span
    localparam int MAG_W  = 16;             // magnitude of the interval slope
    localparam int QUO_W  = 16;             // quotient bits
    localparam int PROD_W = OFS_W + MAG_W;  // offset * magnitude

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Item kinds carried on s_tuser
    localparam logic [1:0] FUNC_DIST  = 2'd0;
    localparam logic [1:0] FUNC_ENC   = 2'd1;
    localparam logic [1:0] FUNC_PRESS = 2'd2;

    // Press patterns
    localparam logic [1:0] PRESS_SINGLE = 2'd0;
    localparam logic [1:0] PRESS_DOUBLE = 2'd1;
    localparam logic [1:0] PRESS_LONG   = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NEAR_LIMIT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FAR_BASE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FAR_STEP      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_ON      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_NEAR = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_FAR  = 3'd5;

    // Reset values
    localparam logic [12:0] NEAR_LIMIT_RST    = 13'd1000;
    localparam logic [12:0] FAR_BASE_RST      = 13'd2300;
    localparam logic [7:0]  FAR_STEP_RST      = 8'd50;
    localparam logic [15:0] PULSE_ON_RST      = 16'd100;
    localparam logic [15:0] INTERVAL_NEAR_RST = 16'd50;
    localparam logic [15:0] INTERVAL_FAR_RST  = 16'd1000;
    localparam logic [13:0] FAR_LIMIT_RST     = 14'd2300;
    localparam logic [5:0]  DIST_COUNT_RST    = 6'd16;
    localparam logic [4:0]  VOL_COUNT_RST     = 5'd25;
    localparam logic [13:0] FAR_LIMIT_MAX     = 14'h3FFF;

    // Input beat, last member in the lowest bits
    typedef struct packed {
        logic [3:0]  pad;
        logic [1:0]  press_kind;
        logic        dt_level;
        logic        clk_level;
        logic [31:0] now_ms;
        logic [15:0] distance_mm;
    } php_item_t;

    // Result beat, last member in the lowest bits
    typedef struct packed {
        logic [3:0]  pad;
        logic        picture_request;
        logic [4:0]  volume_level;
        logic [5:0]  distance_step;
        logic [13:0] far_limit_mm;
        logic        calibrating;
        logic        motor_on;
    } php_result_t;

    localparam int ITEM_W   = $bits(php_item_t);
    localparam int RESULT_W = $bits(php_result_t);

endpackage

>>> rtl/php_serial_mul.sv
// Bit-serial shift-add multiplier: one multiplier bit per cycle.
// Used for the distance offset times the interval slope magnitude.
// Depends on php_pkg.
module php_serial_mul
    import php_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [OFS_W-1:0]  a,
    input  logic [MAG_W-1:0]  b,
    output logic              done,
    output logic [PROD_W-1:0] product
);

    localparam int CNT_W = $clog2(MAG_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [OFS_W-1:0] a_reg;
    logic [OFS_W-1:0] hi_reg;
    logic [MAG_W-1:0] lo_reg;
    logic [OFS_W:0]   sum;

    // add the multiplicand when the current multiplier bit is set
    assign sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, a_reg} : {(OFS_W+1){1'b0}});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(MAG_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg  <= a;
            hi_reg <= '0;
            lo_reg <= b;
        end
        else if (busy_reg)
        begin
            // shift the partial product right by one
            hi_reg <= sum[OFS_W:1];
            lo_reg <= {sum[0], lo_reg[MAG_W-1:1]};
        end
    end

    assign done    = done_reg;
    assign product = {hi_reg, lo_reg};

endmodule

>>> rtl/php_serial_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
// The numerator must be below den * 2^QUO_W, so the quotient fits QUO_W bits.
// Depends on php_pkg.
module php_serial_div
    import php_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [PROD_W-1:0] num,
    input  logic [OFS_W-1:0]  den,
    output logic              done,
    output logic [QUO_W-1:0]  quot
);

    localparam int CNT_W = $clog2(QUO_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [OFS_W-1:0] den_reg;
    logic [OFS_W-1:0] rem_reg;
    logic [QUO_W-1:0] lo_reg;
    logic [OFS_W:0]   trial;
    logic [OFS_W:0]   diff;
    logic             ge;

    assign trial = {rem_reg, lo_reg[QUO_W-1]};
    assign ge    = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(QUO_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            // upper numerator bits are already below the divisor
            den_reg <= den;
            rem_reg <= num[PROD_W-1:QUO_W];
            lo_reg  <= num[QUO_W-1:0];
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[OFS_W-1:0] : trial[OFS_W-1:0];
            lo_reg  <= {lo_reg[QUO_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = lo_reg;

endmodule

>>> rtl/proximity_haptic_pulser_core.sv
// Top level of the proximity haptic pulser: control sequencer, block state,
// configuration registers and output register. Depends on php_pkg,
// php_serial_mul and php_serial_div.
//
//  channel   dir  beat contents                         handshake
//  s_*       in   tuser=func, tdata=item fields         s_tvalid/s_tready
//  m_*       out  tdata=result fields                   m_tvalid/m_tready
//  cfg_*     in   register index and write data         cfg_we, no wait
//
// A distance sample inside the window in normal mode, with distinct window edges, goes
// through the serial multiply and then the serial divide before its result loads; every
// other item loads its result straight after evaluation. One item is in work at a time;
// s_tready returns with the load. A stalled result holds the next item only at its
// final load.
// Reset is asynchronous; it restores all but the item, func and interval registers.
module proximity_haptic_pulser_core
    import php_pkg::*;
#(
    parameter int MAX_DIST_STEPS = 32,
    parameter int MAX_VOLUME     = 20
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // distance_mm[15:0], now_ms[47:16], clk_level[48], dt_level[49],
    // press_kind[51:50], zero fill[55:52]
    input  logic [ITEM_W-1:0]     s_tdata,
    // func[1:0]
    input  logic [1:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // motor_on[0], calibrating[1], far_limit_mm[15:2], distance_step[21:16],
    // volume_level[26:22], picture_request[27], zero fill[31:28]
    output logic [RESULT_W-1:0]   m_tdata
);

    localparam logic [5:0] DIST_MAX = 6'(MAX_DIST_STEPS);
    localparam logic [4:0] VOL_MAX  = 5'(MAX_VOLUME);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_MUL,
        ST_DIV,
        ST_FIN
    } state_t;

    state_t state_reg;

    // configuration
    logic [12:0] near_limit_reg;
    logic [12:0] far_base_reg;
    logic [7:0]  far_step_reg;
    logic [15:0] pulse_on_reg;
    logic [15:0] ivl_near_reg;
    logic [15:0] ivl_far_reg;

    // block state
    logic        cal_reg,     cal_next;
    logic        pin_reg,     pin_next;
    logic        flag_reg,    flag_next;
    logic [31:0] last_ms_reg, last_ms_next;
    logic [13:0] far_reg,     far_next;
    logic [5:0]  dist_reg,    dist_next;
    logic [4:0]  vol_reg,     vol_next;
    logic        lclk_reg,    lclk_next;
    logic        pic_next;

    // item and result
    php_item_t   item_reg;
    logic [1:0]  func_reg;
    logic [15:0] iv_reg;
    logic        m_tvalid_reg;
    php_result_t result_reg;
    php_result_t result_next;

    // datapath
    logic              in_window;
    logic              far_eq_near;
    logic              go_mul;
    logic [OFS_W-1:0]  ofs;
    logic [OFS_W-1:0]  span;
    logic              slope_neg;
    logic [MAG_W-1:0]  slope_mag;
    logic              mul_start;
    logic              mul_done;
    logic [PROD_W-1:0] product;
    logic              div_start;
    logic              div_done;
    logic [QUO_W-1:0]  quot;
    logic [17:0]       quot_s;
    logic [17:0]       iv_sum;
    logic [15:0]       iv_calc;
    logic [31:0]       elapsed;
    logic              out_free;
    logic              commit;
    logic              enc_up;
    logic [5:0]        dist_step;
    logic [4:0]        vol_step;
    logic [13:0]       far_prod;
    logic [14:0]       far_sum;
    logic [13:0]       far_cal;

    assign out_free = !m_tvalid_reg || m_tready;
    assign commit   = (state_reg == ST_FIN) && out_free;

    assign in_window   = ({3'b000, near_limit_reg} <= item_reg.distance_mm) &&
                         (item_reg.distance_mm <= {2'b00, far_reg});
    assign far_eq_near = far_reg == {1'b0, near_limit_reg};
    assign go_mul      = (func_reg == FUNC_DIST) && !cal_reg && in_window && !far_eq_near;

    // inside the window the offset fits the span width
    assign ofs       = OFS_W'(item_reg.distance_mm - {3'b000, near_limit_reg});
    assign span      = far_reg - {1'b0, near_limit_reg};
    assign slope_neg = ivl_far_reg < ivl_near_reg;
    assign slope_mag = slope_neg ? (ivl_near_reg - ivl_far_reg) : (ivl_far_reg - ivl_near_reg);

    assign mul_start = (state_reg == ST_EVAL) && go_mul;
    assign div_start = (state_reg == ST_MUL) && mul_done;

    php_serial_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (ofs),
        .b       (slope_mag),
        .done    (mul_done),
        .product (product)
    );

    php_serial_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (product),
        .den   (span),
        .done  (div_done),
        .quot  (quot)
    );

    // apply the slope sign after dividing magnitudes: truncation toward zero
    assign quot_s  = slope_neg ? (18'd0 - {2'b00, quot}) : {2'b00, quot};
    assign iv_sum  = quot_s + {2'b00, ivl_near_reg};
    assign iv_calc = iv_sum[17] ? 16'd0 : (iv_sum[16] ? 16'hFFFF : iv_sum[15:0]);

    assign elapsed = item_reg.now_ms - last_ms_reg;

    // encoder step with saturation on both counts
    assign enc_up = item_reg.dt_level != item_reg.clk_level;

    always_comb
    begin
        if (enc_up)
        begin
            dist_step = (dist_reg >= DIST_MAX) ? DIST_MAX : dist_reg + 6'd1;
            vol_step  = (vol_reg >= VOL_MAX) ? VOL_MAX : vol_reg + 5'd1;
        end
        else
        begin
            dist_step = (dist_reg == 6'd0) ? 6'd0 :
                        ((dist_reg - 6'd1 > DIST_MAX) ? DIST_MAX : dist_reg - 6'd1);
            vol_step  = (vol_reg == 5'd0) ? 5'd0 :
                        ((vol_reg - 5'd1 > VOL_MAX) ? VOL_MAX : vol_reg - 5'd1);
        end
    end

    assign far_prod = dist_step * far_step_reg;
    assign far_sum  = {2'b00, far_base_reg} + {1'b0, far_prod};
    assign far_cal  = far_sum[14] ? FAR_LIMIT_MAX : far_sum[13:0];

    always_comb
    begin
        cal_next     = cal_reg;
        pin_next     = pin_reg;
        flag_next    = flag_reg;
        last_ms_next = last_ms_reg;
        far_next     = far_reg;
        dist_next    = dist_reg;
        vol_next     = vol_reg;
        lclk_next    = lclk_reg;
        pic_next     = 1'b0;
        case (func_reg)
            FUNC_DIST:
            begin
                if (!cal_reg)
                begin
                    if (in_window)
                    begin
                        if (!flag_reg && (elapsed >= {16'd0, iv_reg}))
                        begin
                            pin_next     = 1'b1;
                            flag_next    = 1'b1;
                            last_ms_next = item_reg.now_ms;
                        end
                        else if (flag_reg && (elapsed >= {16'd0, pulse_on_reg}))
                        begin
                            pin_next     = 1'b0;
                            flag_next    = 1'b0;
                            last_ms_next = item_reg.now_ms;
                        end
                    end
                    else
                    begin
                        pin_next  = 1'b0;
                        flag_next = 1'b0;
                    end
                end
            end
            FUNC_ENC:
            begin
                if (item_reg.clk_level != lclk_reg)
                begin
                    dist_next = dist_step;
                    vol_next  = vol_step;
                    if (cal_reg)
                    begin
                        far_next = far_cal;
                    end
                end
                lclk_next = item_reg.clk_level;
            end
            FUNC_PRESS:
            begin
                case (item_reg.press_kind)
                    PRESS_SINGLE:
                    begin
                        pin_next = 1'b0;
                        if (cal_reg)
                        begin
                            cal_next = 1'b0;
                        end
                        else
                        begin
                            pic_next = 1'b1;
                        end
                    end
                    PRESS_LONG:
                    begin
                        if (!cal_reg)
                        begin
                            cal_next = 1'b1;
                            pin_next = 1'b0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        result_next                 = '0;
        result_next.motor_on        = pin_next;
        result_next.calibrating     = cal_next;
        result_next.far_limit_mm    = far_next;
        result_next.distance_step   = dist_next;
        result_next.volume_level    = vol_next;
        result_next.picture_request = pic_next;
    end

    // sequencer, block state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cal_reg      <= 1'b0;
            pin_reg      <= 1'b0;
            flag_reg     <= 1'b0;
            last_ms_reg  <= '0;
            far_reg      <= FAR_LIMIT_RST;
            dist_reg     <= DIST_COUNT_RST;
            vol_reg      <= VOL_COUNT_RST;
            lclk_reg     <= 1'b1;
            m_tvalid_reg <= 1'b0;
            result_reg   <= '0;
        end
        else
        begin
            if (m_tready && !commit)
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        state_reg <= ST_EVAL;
                    end
                end
                ST_EVAL:
                begin
                    state_reg <= go_mul ? ST_MUL : ST_FIN;
                end
                ST_MUL:
                begin
                    if (mul_done)
                    begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    // hold until the output register can take the beat
                    if (out_free)
                    begin
                        cal_reg      <= cal_next;
                        pin_reg      <= pin_next;
                        flag_reg     <= flag_next;
                        last_ms_reg  <= last_ms_next;
                        far_reg      <= far_next;
                        dist_reg     <= dist_next;
                        vol_reg      <= vol_next;
                        lclk_reg     <= lclk_next;
                        result_reg   <= result_next;
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg <= php_item_t'(s_tdata);
            func_reg <= s_tuser;
        end
        // equal edges use the near interval; the divider result replaces it
        if (state_reg == ST_EVAL)
        begin
            iv_reg <= ivl_near_reg;
        end
        else if ((state_reg == ST_DIV) && div_done)
        begin
            iv_reg <= iv_calc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            near_limit_reg <= NEAR_LIMIT_RST;
            far_base_reg   <= FAR_BASE_RST;
            far_step_reg   <= FAR_STEP_RST;
            pulse_on_reg   <= PULSE_ON_RST;
            ivl_near_reg   <= INTERVAL_NEAR_RST;
            ivl_far_reg    <= INTERVAL_FAR_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_NEAR_LIMIT:    near_limit_reg <= cfg_data[12:0];
                REG_FAR_BASE:      far_base_reg   <= cfg_data[12:0];
                REG_FAR_STEP:      far_step_reg   <= cfg_data[7:0];
                REG_PULSE_ON:      pulse_on_reg   <= cfg_data;
                REG_INTERVAL_NEAR: ivl_near_reg   <= cfg_data;
                REG_INTERVAL_FAR:  ivl_far_reg    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = result_reg;

endmodule

>>> rtl/php_checker.sv
// Port-level checker for proximity_haptic_pulser_core, bound to the top level.
// Watches the stream channels only. Depends on php_pkg.
module php_checker
    import php_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [RESULT_W-1:0]   m_tdata
);

    php_result_t res;

    assign res = php_result_t'(m_tdata);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // one item in work at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while an item is in work");

    // calibration keeps the motor pin low
    a_cal_motor_off: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res.calibrating |-> !res.motor_on)
        else $error("motor on during calibration");

    // a picture request only comes from a single press in normal mode
    a_pic_normal: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res.picture_request |-> !res.calibrating && !res.motor_on)
        else $error("picture request with calibration or motor on");

endmodule

bind proximity_haptic_pulser_core php_checker u_php_checker (.*);

>>> tb/proximity_haptic_pulser_core_test.sv
// Self-checking testbench for proximity_haptic_pulser_core: a directed table, then
// random distance, encoder and button beats under several register settings.
// Depends on php_pkg and the core; results are checked against a predictor in this file.
module proximity_haptic_pulser_core_test;
    import php_pkg::*;

    localparam int PERIOD         = 12;
    localparam int RESET_CYCLES   = 2;
    localparam int MAX_DIST_STEPS = 32;
    localparam int MAX_VOLUME     = 20;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 69;
    localparam int HOLD_CYCLES    = 300;
    localparam int TAIL_CYCLES    = 48;
    localparam int LIMIT_CYCLES   = 600000;
    localparam int REPORT_LIMIT   = 10;
    localparam int IDLE_LIGHT     = 17;
    localparam int IDLE_HEAVY     = 76;

    localparam logic [1:0] FUNC_SPARE  = 2'd3;
    localparam logic [1:0] PRESS_SPARE = 2'd3;

    localparam php_result_t AT_RESET =
        {4'd0, 1'b0, VOL_COUNT_RST, DIST_COUNT_RST, FAR_LIMIT_RST, 1'b0, 1'b0};
    localparam php_result_t PICTURE_AT_RESET =
        {4'd0, 1'b1, VOL_COUNT_RST, DIST_COUNT_RST, FAR_LIMIT_RST, 1'b0, 1'b0};

    typedef enum int {PACE_SENDER_LIGHT, PACE_SENDER_HEAVY, PACE_FREE} pace_t;

    typedef struct packed {
        logic [1:0]  kind;
        php_item_t   item;
        logic        typed;
        php_result_t want;
    } plan_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [ITEM_W-1:0]     s_tdata = '0;
    logic [1:0]            s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [RESULT_W-1:0]   m_tdata;

    // register copies
    logic [12:0] cf_near  = NEAR_LIMIT_RST;
    logic [12:0] cf_base  = FAR_BASE_RST;
    logic [7:0]  cf_step  = FAR_STEP_RST;
    logic [15:0] cf_pulse = PULSE_ON_RST;
    logic [15:0] cf_ivn   = INTERVAL_NEAR_RST;
    logic [15:0] cf_ivf   = INTERVAL_FAR_RST;

    // pulser state as seen from outside
    logic        st_cal       = 1'b0;
    logic        st_pin       = 1'b0;
    logic        st_flag      = 1'b0;
    logic        st_clk_last  = 1'b1;
    logic [31:0] st_toggle_ms = '0;
    logic [13:0] st_far       = FAR_LIMIT_RST;
    int          st_dist      = int'(DIST_COUNT_RST);
    int          st_vol       = int'(VOL_COUNT_RST);

    php_result_t awaited_beats[$];
    int          mismatch_count = 0;
    int          hold_left = 0;
    pace_t       pace = PACE_SENDER_LIGHT;
    logic [31:0] clock_ms = '0;
    logic        turn_up = 1'b1;
    plan_row_t   plan [25];

    proximity_haptic_pulser_core #(
        .MAX_DIST_STEPS(MAX_DIST_STEPS),
        .MAX_VOLUME    (MAX_VOLUME)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #(PERIOD / 2) clk = ~clk;

    function automatic plan_row_t row(input logic [1:0] kind, input logic [15:0] reading_mm,
                                      input logic [31:0] stamp, input logic enc_clk,
                                      input logic enc_dt, input logic [1:0] press,
                                      input logic typed, input php_result_t want);
        plan_row_t r;
        r.kind = kind;
        r.item = '0;
        r.item.distance_mm = reading_mm;
        r.item.now_ms = stamp;
        r.item.clk_level = enc_clk;
        r.item.dt_level = enc_dt;
        r.item.press_kind = press;
        r.typed = typed;
        r.want = want;
        return r;
    endfunction

    function automatic int idle_pct(input bit sink_side);
        case (pace)
            PACE_SENDER_LIGHT: return sink_side ? IDLE_HEAVY : IDLE_LIGHT;
            PACE_SENDER_HEAVY: return sink_side ? IDLE_LIGHT : IDLE_HEAVY;
            default:           return 0;
        endcase
    endfunction

    // Advance the pulser state by one beat and return the result it reports.
    function automatic php_result_t predict_pulser(input logic [1:0] kind,
                                                   input php_item_t it);
        php_result_t res;
        logic [31:0] elapsed;
        longint      span;
        longint      num;
        longint      iv;
        int unsigned reach;
        res = '0;
        case (kind)
            FUNC_DIST:
            begin
                if (!st_cal)
                begin
                    if (it.distance_mm >= 16'(cf_near) && it.distance_mm <= 16'(st_far))
                    begin
                        if (st_far == 14'(cf_near))
                            iv = longint'(cf_ivn);
                        else
                        begin
                            span = longint'(st_far) - longint'(cf_near);
                            num = (longint'(it.distance_mm) - longint'(cf_near)) *
                                  (longint'(cf_ivf) - longint'(cf_ivn));
                            iv = num / span + longint'(cf_ivn);
                            if (iv < 0)
                                iv = 0;
                            if (iv > 65535)
                                iv = 65535;
                        end
                        elapsed = it.now_ms - st_toggle_ms;
                        if (!st_flag && longint'(elapsed) >= iv)
                        begin
                            st_pin = 1'b1;
                            st_flag = 1'b1;
                            st_toggle_ms = it.now_ms;
                        end
                        else if (st_flag && elapsed >= 32'(cf_pulse))
                        begin
                            st_pin = 1'b0;
                            st_flag = 1'b0;
                            st_toggle_ms = it.now_ms;
                        end
                    end
                    else
                    begin
                        // out of window: drop the pin and the flag, keep the timestamp
                        st_pin = 1'b0;
                        st_flag = 1'b0;
                    end
                end
            end
            FUNC_ENC:
            begin
                if (it.clk_level != st_clk_last)
                begin
                    if (it.dt_level != it.clk_level)
                    begin
                        st_dist++;
                        st_vol++;
                    end
                    else
                    begin
                        st_dist--;
                        st_vol--;
                    end
                    if (st_dist < 0)
                        st_dist = 0;
                    if (st_dist > MAX_DIST_STEPS)
                        st_dist = MAX_DIST_STEPS;
                    if (st_vol < 0)
                        st_vol = 0;
                    if (st_vol > MAX_VOLUME)
                        st_vol = MAX_VOLUME;
                    if (st_cal)
                    begin
                        reach = 32'(cf_base) + 32'(st_dist) * 32'(cf_step);
                        st_far = (reach > 32'(FAR_LIMIT_MAX)) ? FAR_LIMIT_MAX : 14'(reach);
                    end
                end
                st_clk_last = it.clk_level;
            end
            FUNC_PRESS:
            begin
                if (it.press_kind == PRESS_SINGLE)
                begin
                    st_pin = 1'b0;
                    if (st_cal)
                        st_cal = 1'b0;
                    else
                        res.picture_request = 1'b1;
                end
                else if (it.press_kind == PRESS_LONG && !st_cal)
                begin
                    st_cal = 1'b1;
                    st_pin = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
        res.motor_on = st_pin;
        res.calibrating = st_cal;
        res.far_limit_mm = st_far;
        res.distance_step = 6'(st_dist);
        res.volume_level = 5'(st_vol);
        return res;
    endfunction

    // Call at a falling edge; returns at the falling edge after the beat is taken.
    task automatic offer_item(input logic [1:0] kind, input php_item_t it,
                              input logic typed, input php_result_t want);
        php_result_t guess;
        while ($urandom_range(0, 99) < idle_pct(1'b0))
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= it;
        s_tuser <= kind;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        guess = predict_pulser(kind, it);
        awaited_beats.push_back(typed ? want : guess);
        @(negedge clk);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (awaited_beats.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[CFG_DATA_W-1:0];
        case (idx)
            REG_NEAR_LIMIT:    cf_near = value[12:0];
            REG_FAR_BASE:      cf_base = value[12:0];
            REG_FAR_STEP:      cf_step = value[7:0];
            REG_PULSE_ON:      cf_pulse = value[15:0];
            REG_INTERVAL_NEAR: cf_ivn = value[15:0];
            REG_INTERVAL_FAR:  cf_ivf = value[15:0];
            default:
            begin
            end
        endcase
        @(negedge clk);
    endtask

    // Mostly small values so that pulses happen often; the ends show up too.
    function automatic int unsigned reg_pick(input int unsigned top);
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return 0;
        if (roll == 1)
            return top;
        if (roll < 6)
            return $urandom_range(0, (top < 2000) ? top : 2000);
        return $urandom_range(0, top);
    endfunction

    task automatic draw_reading(output logic [1:0] kind, output php_item_t it);
        int unsigned roll;
        int unsigned pick;
        roll = $urandom_range(0, 99);
        it.pad = '0;
        it.distance_mm = 16'($urandom);
        it.now_ms = $urandom;
        it.clk_level = 1'($urandom);
        it.dt_level = 1'($urandom);
        it.press_kind = 2'($urandom);
        kind = FUNC_SPARE;
        if (st_cal)
        begin
            if (roll < 65)
                kind = FUNC_ENC;
            else if (roll < 75)
            begin
                kind = FUNC_PRESS;
                it.press_kind = PRESS_SINGLE;
            end
            else if (roll < 85)
                kind = FUNC_PRESS;
            else if (roll < 93)
                kind = FUNC_DIST;
        end
        else
        begin
            if (roll < 62)
                kind = FUNC_DIST;
            else if (roll < 80)
                kind = FUNC_ENC;
            else if (roll < 84)
            begin
                kind = FUNC_PRESS;
                it.press_kind = PRESS_LONG;
            end
            else if (roll < 90)
            begin
                kind = FUNC_PRESS;
                it.press_kind = PRESS_SINGLE;
            end
            else if (roll < 95)
            begin
                kind = FUNC_PRESS;
                it.press_kind = ($urandom_range(0, 1) == 0) ? PRESS_DOUBLE : PRESS_SPARE;
            end
        end
        if (kind == FUNC_DIST)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 75 && st_far >= 14'(cf_near))
                it.distance_mm = 16'($urandom_range(32'(cf_near), 32'(st_far)));
            else if (pick < 88)
            begin
                case ($urandom_range(0, 3))
                    0:       it.distance_mm = 16'(cf_near);
                    1:       it.distance_mm = 16'(st_far);
                    2:       it.distance_mm = 16'(cf_near) - 16'd1;
                    default: it.distance_mm = 16'(st_far) + 16'd1;
                endcase
            end
            // advance time in small steps, with a rare long gap or a jump anywhere
            pick = $urandom_range(0, 99);
            if (pick < 70)
                clock_ms = clock_ms + $urandom_range(0, 150);
            else if (pick < 90)
                clock_ms = clock_ms + $urandom_range(0, 1200);
            else if (pick < 97)
                clock_ms = clock_ms + $urandom_range(0, 70000);
            else
                clock_ms = $urandom;
            it.now_ms = clock_ms;
        end
        else if (kind == FUNC_ENC)
        begin
            // walk the counts in runs so that both ends saturate
            it.clk_level = ($urandom_range(0, 99) < 85) ? ~st_clk_last : st_clk_last;
            if ($urandom_range(0, 99) < 6)
                turn_up = ~turn_up;
            it.dt_level = it.clk_level ^ turn_up;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        php_result_t got;
        php_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (awaited_beats.size() == 0)
            begin
                if (mismatch_count < REPORT_LIMIT)
                    $display("unexpected result beat %h", m_tdata);
                mismatch_count++;
            end
            else
            begin
                want = awaited_beats.pop_front();
                if (got.motor_on !== want.motor_on || got.calibrating !== want.calibrating ||
                    got.far_limit_mm !== want.far_limit_mm ||
                    got.distance_step !== want.distance_step ||
                    got.volume_level !== want.volume_level ||
                    got.picture_request !== want.picture_request)
                begin
                    if (mismatch_count < REPORT_LIMIT)
                        $display({"mismatch: expected motor=%0b cal=%0b far=%0d step=%0d ",
                                  "vol=%0d pic=%0b, got motor=%0b cal=%0b far=%0d step=%0d ",
                                  "vol=%0d pic=%0b"},
                                 want.motor_on, want.calibrating, want.far_limit_mm,
                                 want.distance_step, want.volume_level, want.picture_request,
                                 got.motor_on, got.calibrating, got.far_limit_mm,
                                 got.distance_step, got.volume_level, got.picture_request);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin : result_sink
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= idle_pct(1'b1));
        end
    end

    initial
    begin : watchdog
        #(LIMIT_CYCLES * PERIOD);
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin : stimulus
        logic [1:0]  kind;
        php_item_t   it;
        int unsigned v_near;
        int unsigned v_base;
        int unsigned v_step;
        int unsigned v_pulse;
        int unsigned v_ivn;
        int unsigned v_ivf;
        plan = '{
            row(FUNC_ENC,   16'd0,     32'd0,        1'b1, 1'b0, PRESS_SINGLE, 1'b1, AT_RESET),
            row(FUNC_PRESS, 16'd0,     32'd0,        1'b0, 1'b0, PRESS_DOUBLE, 1'b1, AT_RESET),
            row(FUNC_SPARE, 16'hFFFF,  32'hFFFFFFFF, 1'b0, 1'b1, PRESS_SPARE,  1'b1, AT_RESET),
            row(FUNC_PRESS, 16'd0,     32'd0,        1'b0, 1'b0, PRESS_SPARE,  1'b1, AT_RESET),
            row(FUNC_DIST,  16'd0,     32'd0,        1'b0, 1'b0, PRESS_SINGLE, 1'b1, AT_RESET),
            // pulse at the near edge, hold, release at the far edge, pulse again
            row(FUNC_DIST,  16'd1000,  32'd50,       1'b0, 1'b0, PRESS_SINGLE, 1'b0, '0),
            row(FUNC_DIST,  16'd1000,  32'd100,      1'b0, 1'b0, PRESS_SINGLE, 1'b0, '0),
            row(FUNC_DIST,  16'd2300,  32'd150,      1'b0, 1'b0, PRESS_SINGLE, 1'b0, '0),
            row(FUNC_DIST,  16'd2300,  32'd1150,     1'b0, 1'b0, PRESS_SINGLE, 1'b0, '0),
            row(FUNC_DIST,  16'hFFFF,  32'd1200,     1'b0, 1'b0, PRESS_SINGLE, 1'b0, '0),
            row(FUNC_DIST,  16'd2301,  32'd1300,     1'b0, 1'b0, PRESS_SINGLE, 1'b0, '0),
            row(FUNC_DIST,  16'd1650,  32'hFFFFFFFF, 1'b0, 1'b0, PRESS_SINGLE, 1'b0, '0),
            // pin drops on a press while the pulse flag stays set; time wraps
            row(FUNC_PRESS, 16'd0,     32'd0,        1'b0, 1'b0, PRESS_SINGLE, 1'b1,
                PICTURE_AT_RESET),
            row(FUNC_DIST,  16'd1650,  32'd99,       1'b0, 1'b0, PRESS_SINGLE, 1'b0, '0),
            row(FUNC_ENC,   16'd0,     32'd0,        1'b0, 1'b1, PRESS_SINGLE, 1'b0, '0),
            row(FUNC_ENC,   16'd0,     32'd0,        1'b1, 1'b1, PRESS_SINGLE, 1'b0, '0),
            row(FUNC_PRESS, 16'd0,     32'd0,        1'b0, 1'b0, PRESS_LONG,   1'b0, '0),
            row(FUNC_PRESS, 16'd0,     32'd0,        1'b0, 1'b0, PRESS_LONG,   1'b0, '0),
            row(FUNC_DIST,  16'd1500,  32'd5000,     1'b0, 1'b0, PRESS_SINGLE, 1'b0, '0),
            row(FUNC_ENC,   16'd0,     32'd0,        1'b0, 1'b0, PRESS_SINGLE, 1'b0, '0),
            row(FUNC_ENC,   16'd0,     32'd0,        1'b0, 1'b1, PRESS_SINGLE, 1'b0, '0),
            row(FUNC_ENC,   16'd0,     32'd0,        1'b1, 1'b0, PRESS_SINGLE, 1'b0, '0),
            row(FUNC_PRESS, 16'd0,     32'd0,        1'b0, 1'b0, PRESS_DOUBLE, 1'b0, '0),
            row(FUNC_PRESS, 16'd0,     32'd0,        1'b0, 1'b0, PRESS_SINGLE, 1'b0, '0),
            row(FUNC_PRESS, 16'd0,     32'd0,        1'b0, 1'b0, PRESS_SPARE,  1'b0, '0)
        };

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < $size(plan); i++)
            offer_item(plan[i].kind, plan[i].item, plan[i].typed, plan[i].want);

        clock_ms = $urandom;
        for (int p = 0; p < PHASES; p++)
        begin
            pace = (p < 3) ? PACE_SENDER_LIGHT : (p < 6) ? PACE_SENDER_HEAVY : PACE_FREE;
            settle();
            v_near = cf_near;
            v_base = cf_base;
            v_step = cf_step;
            v_pulse = cf_pulse;
            v_ivn = cf_ivn;
            v_ivf = cf_ivf;
            case (p)
                0:
                    // collapse the window: near edge on the current far edge
                    v_near = (st_far <= 14'd8191) ? 32'(st_far) : 0;
                1:
                begin
                    v_near = 0;
                    v_base = 0;
                    v_step = 0;
                    v_pulse = 0;
                    v_ivn = 0;
                    v_ivf = 0;
                end
                2:
                begin
                    v_near = 8191;
                    v_base = 8191;
                    v_step = 255;
                    v_pulse = 65535;
                    v_ivn = 65535;
                    v_ivf = 65535;
                end
                default:
                begin
                    v_near = reg_pick(8191);
                    v_base = reg_pick(8191);
                    v_step = reg_pick(255);
                    v_pulse = reg_pick(65535);
                    v_ivn = reg_pick(65535);
                    v_ivf = reg_pick(65535);
                end
            endcase
            write_reg(REG_NEAR_LIMIT, v_near);
            write_reg(REG_FAR_BASE, v_base);
            write_reg(REG_FAR_STEP, v_step);
            write_reg(REG_PULSE_ON, v_pulse);
            write_reg(REG_INTERVAL_NEAR, v_ivn);
            write_reg(REG_INTERVAL_FAR, v_ivf);
            cfg_we <= 1'b0;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // hold the result side off while beats keep coming, to back up the input
                if (p == 6 && n == 10)
                    hold_left = HOLD_CYCLES;
                draw_reading(kind, it);
                offer_item(kind, it, 1'b0, '0);
            end
        end

        settle();
        if (mismatch_count == 0 && awaited_beats.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
